>>> hdl/lphs_pkg.sv
package lphs_pkg;

  // fixed field widths of the channels
  localparam int ELEM_W  = 31;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 11;

  // home slot multiplier
  localparam int HASH_MULT = 101;

  // fill limit after reset
  localparam logic [CFG_W-1:0] FILL_LIMIT_RESET = 11'd512;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_FIND   = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_FIRST  = 3'd3;
  localparam logic [2:0] OP_NEXT   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  // slot tags
  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  typedef struct packed {
    logic [2:0]        operation;
    logic [ELEM_W-1:0] element;
  } lphs_in_t;

  typedef struct packed {
    logic               hit;
    logic [ELEM_W-1:0]  value;
    logic [COUNT_W-1:0] live_count;
    logic [1:0]         status;
  } lphs_out_t;

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_SCAN,
    S_REPLY
  } lphs_state_t;

endpackage

>>> hdl/lphs_ram.sv
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/lphs_hash.sv
module lphs_hash #(
  parameter int TABLE_SLOTS = 1024,
  parameter int SW          = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [SW-1:0]                  elem,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] home
);
  import lphs_pkg::*;

  localparam int AW   = $clog2(TABLE_SLOTS);
  localparam bit POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  generate
    if (POW2) begin : g_pow2
      localparam int EW = (SW > AW) ? SW : AW;

      logic [EW-1:0]   elem_ext;
      logic [AW+6:0]   prod;
      logic            done_r;
      logic [AW-1:0]   home_r;

      // low address bits times the multiplier, mod a power of two
      assign elem_ext = EW'(elem);
      assign prod     = (AW+7)'(elem_ext[AW-1:0]) * (AW+7)'(HASH_MULT);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          home_r <= prod[AW-1:0];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end else begin : g_digit
      localparam int NDIG = (SW + 3) / 4;
      localparam int PW   = NDIG * 4;
      localparam int CNTW = $clog2(NDIG + 1);

      logic [PW-1:0]   sh_r;
      logic [AW-1:0]   rem_r;
      logic [CNTW-1:0] dig_cnt_r;
      logic            busy_r;
      logic            done_r;
      logic [AW-1:0]   home_r;
      logic [AW-1:0]   rem_step;
      logic [AW-1:0]   home_calc;

      // one hex digit per cycle: rem = (rem*16 + digit) mod slots
      always_comb begin
        logic [AW+3:0] x;
        x = {rem_r, sh_r[PW-1 -: 4]};
        for (int k = 3; k >= 0; k--) begin
          if (x >= (((AW+4)'(TABLE_SLOTS)) << k)) begin
            x = x - (((AW+4)'(TABLE_SLOTS)) << k);
          end
        end
        rem_step = x[AW-1:0];
      end

      // final step: (rem * multiplier) mod slots
      always_comb begin
        logic [AW+6:0] y;
        y = (AW+7)'(rem_r) * (AW+7)'(HASH_MULT);
        for (int k = 6; k >= 0; k--) begin
          if (y >= (((AW+7)'(TABLE_SLOTS)) << k)) begin
            y = y - (((AW+7)'(TABLE_SLOTS)) << k);
          end
        end
        home_calc = y[AW-1:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
          end else if (busy_r && (dig_cnt_r == '0)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          sh_r      <= PW'(elem);
          rem_r     <= '0;
          dig_cnt_r <= CNTW'(NDIG);
        end else if (busy_r) begin
          if (dig_cnt_r != '0) begin
            rem_r     <= rem_step;
            sh_r      <= sh_r << 4;
            dig_cnt_r <= dig_cnt_r - 1'b1;
          end else begin
            home_r <= home_calc;
          end
        end
      end

      assign done = done_r;
      assign home = home_r;
    end
  endgenerate

endmodule

>>> hdl/linear_probe_hash_set_core.sv
// channel | handshake              | word
// --------+------------------------+------------------------------------------
// in      | in_valid / in_ready    | in_data : operation, element
// out     | out_valid / out_ready  | out_data : hit, value, live_count, status
// cfg     | cfg_valid / cfg_ready  | cfg_data : fill_limit, always ready
//
// one operation at a time; invalid, full and unknown words go from accept straight to the reply state.
// find/insert/remove/next: hash (a single multiply for a power-of-two table, else digit by digit),
// then one slot per cycle from the slot memory's registered read port, then the reply state.
// first and next scan forward one slot per cycle to the end of the table.
// reset and clear sweep every slot of the slot memory with in_ready low.
// a finished reply holds in the output register until out_ready; next word accepted meanwhile.
module linear_probe_hash_set_core #(
  parameter int TABLE_SLOTS  = 1024,
  parameter int ELEMENT_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lphs_pkg::lphs_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lphs_pkg::lphs_out_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lphs_pkg::CFG_W-1:0] cfg_data
);
  import lphs_pkg::*;

  localparam int SW   = (ELEMENT_BITS < ELEM_W) ? ELEMENT_BITS : ELEM_W;
  localparam int AW   = $clog2(TABLE_SLOTS);
  localparam int CW   = $clog2(TABLE_SLOTS + 1);
  localparam int FW   = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam int MW   = SW + 2;
  localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

  lphs_state_t      state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [SW-1:0]    elem_r, elem_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    live_r, live_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [CFG_W-1:0] fill_limit_r;
  logic             clr_reply_r, clr_reply_nxt;
  logic             res_hit_r, res_hit_nxt;
  logic [SW-1:0]    res_value_r, res_value_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  lphs_out_t        out_r, out_nxt;

  logic             hash_start;
  logic             hash_done;
  logic [AW-1:0]    hash_home;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [MW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [MW-1:0]    ram_rdata;

  logic [1:0]       rd_tag;
  logic [SW-1:0]    rd_val;
  logic [AW-1:0]    addr_inc;
  logic [SW-1:0]    in_elem;
  logic             in_zero;
  logic             needs_elem;
  logic             table_full;

  // slot memory: {tag, value}
  lphs_ram #(
    .WIDTH(MW),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lphs_hash #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .SW         (SW)
  ) u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .start(hash_start),
    .elem (in_elem),
    .done (hash_done),
    .home (hash_home)
  );

  assign rd_tag   = ram_rdata[MW-1 -: 2];
  assign rd_val   = ram_rdata[SW-1:0];
  assign addr_inc = (addr_r == LAST) ? '0 : addr_r + 1'b1;

  // decode of the incoming word
  assign in_elem    = in_data.element[SW-1:0];
  assign in_zero    = (in_elem == '0);
  assign needs_elem = (in_data.operation == OP_INSERT) || (in_data.operation == OP_FIND) ||
                      (in_data.operation == OP_REMOVE) || (in_data.operation == OP_NEXT);
  assign table_full = ((FW'(used_r) + FW'(1)) >= FW'(fill_limit_r)) ||
                      (FW'(used_r) >= FW'(TABLE_SLOTS));

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_limit_r <= FILL_LIMIT_RESET;
    end else if (cfg_valid) begin
      fill_limit_r <= cfg_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      addr_r      <= '0;
      live_r      <= '0;
      used_r      <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      live_r      <= live_nxt;
      used_r      <= used_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    elem_r       <= elem_nxt;
    cnt_r        <= cnt_nxt;
    res_hit_r    <= res_hit_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_r        <= out_nxt;
  end

  // sequencer: wipe, hash, probe, scan, write back, reply
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    elem_nxt       = elem_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    live_nxt       = live_r;
    used_nxt       = used_r;
    clr_reply_nxt  = clr_reply_r;
    res_hit_nxt    = res_hit_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    in_ready       = 1'b0;
    hash_start     = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '0;
    ram_raddr      = addr_r;

    unique case (state_r)
      S_WIPE: begin
        ram_we    = 1'b1;
        ram_wdata = {TAG_EMPTY, {SW{1'b0}}};
        if (addr_r == LAST) begin
          state_nxt     = clr_reply_r ? S_REPLY : S_IDLE;
          clr_reply_nxt = 1'b0;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt         = in_data.operation;
          elem_nxt       = in_elem;
          res_hit_nxt    = 1'b0;
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          if (needs_elem && in_zero) begin
            res_status_nxt = ST_INVALID;
            state_nxt      = S_REPLY;
          end else begin
            unique case (in_data.operation)
              OP_INSERT: begin
                if (table_full) begin
                  res_status_nxt = ST_FULL;
                  state_nxt      = S_REPLY;
                end else begin
                  hash_start = 1'b1;
                  state_nxt  = S_HASH;
                end
              end
              OP_FIND, OP_REMOVE, OP_NEXT: begin
                hash_start = 1'b1;
                state_nxt  = S_HASH;
              end
              OP_FIRST: begin
                ram_raddr = '0;
                addr_nxt  = '0;
                state_nxt = S_SCAN;
              end
              OP_CLEAR: begin
                addr_nxt      = '0;
                live_nxt      = '0;
                used_nxt      = '0;
                clr_reply_nxt = 1'b1;
                state_nxt     = S_WIPE;
              end
              default: begin
                state_nxt = S_REPLY;
              end
            endcase
          end
        end
      end

      S_HASH: begin
        if (hash_done) begin
          ram_raddr = hash_home;
          addr_nxt  = hash_home;
          cnt_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end

      // read data belongs to addr_r; the next slot is read only when the probe moves on
      S_PROBE: begin
        priority if ((rd_tag == TAG_LIVE) && (rd_val == elem_r)) begin
          state_nxt = S_REPLY;
          unique case (op_r)
            OP_FIND: begin
              res_hit_nxt = 1'b1;
            end
            OP_REMOVE: begin
              ram_we      = 1'b1;
              ram_wdata   = {TAG_TOMB, {SW{1'b0}}};
              live_nxt    = live_r - 1'b1;
              res_hit_nxt = 1'b1;
            end
            OP_NEXT: begin
              if (addr_r != LAST) begin
                ram_raddr = addr_inc;
                addr_nxt  = addr_inc;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end else if (rd_tag == TAG_EMPTY) begin
          state_nxt = S_REPLY;
          if (op_r == OP_INSERT) begin
            ram_we      = 1'b1;
            ram_wdata   = {TAG_LIVE, elem_r};
            live_nxt    = live_r + 1'b1;
            used_nxt    = used_r + 1'b1;
            res_hit_nxt = 1'b1;
          end else if (op_r == OP_NEXT) begin
            res_status_nxt = ST_ABSENT;
          end
        end else if (cnt_r == LAST) begin
          // every slot visited without a match or an empty slot
          state_nxt = S_REPLY;
          if (op_r == OP_NEXT) begin
            res_status_nxt = ST_ABSENT;
          end
        end else begin
          ram_raddr = addr_inc;
          addr_nxt  = addr_inc;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end

      // forward scan, no wrap
      S_SCAN: begin
        priority if (rd_tag == TAG_LIVE) begin
          res_value_nxt = rd_val;
          state_nxt     = S_REPLY;
        end else if (addr_r == LAST) begin
          res_value_nxt = '0;
          state_nxt     = S_REPLY;
        end else begin
          ram_raddr = addr_inc;
          addr_nxt  = addr_inc;
        end
      end

      S_REPLY: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.hit        = res_hit_r;
          out_nxt.value      = ELEM_W'(res_value_r);
          out_nxt.live_count = COUNT_W'(live_r);
          out_nxt.status     = res_status_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/lphs_checker.sv
module lphs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input lphs_pkg::lphs_out_t        out_data
);
  import lphs_pkg::*;

  // a stalled reply word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("reply word changed while stalled");

  // one operation in flight: ready drops after each accepted word
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // error statuses carry neither a hit nor a value
  a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> !out_data.hit && (out_data.value == '0))
    else $error("error reply with hit or value");

  // hit and a returned value never come together
  a_hit_or_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> (out_data.value == '0))
    else $error("reply with both hit and value");

endmodule

bind linear_probe_hash_set_core lphs_checker u_lphs_checker (.*);
